// File: sv/element_rms_level_check_assert.svh
// Assertion macros for the element RMS level check block.
// Expects clk and rst to be visible where a macro is used.
`ifndef ELEMENT_RMS_LEVEL_CHECK_ASSERT_SVH
`define ELEMENT_RMS_LEVEL_CHECK_ASSERT_SVH

// Condition holds at every clock edge outside reset.
`define ERLC_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define ERLC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/erlc_pkg.sv
// Shared types and constants for the element RMS level check block.
// No dependencies.
package erlc_pkg;

  localparam int SAMPLE_W = 16;
  localparam int WORD_W   = 32;
  localparam int POS_W    = 10;
  localparam int SUM_W    = 25;
  localparam int RMS_W    = 24;
  localparam int CNT_W    = 7;
  localparam int DCW_W    = 9;
  localparam int ELEM_W   = 6;
  localparam int FAIL_W   = 7;
  localparam int CIDX_W   = 3;
  localparam int MEAN_W   = 34;
  localparam int ACC_W    = 64;
  localparam int ROOT_W   = 32;
  localparam int ITER_W   = 7;

  localparam logic [RMS_W-1:0]  RMS_RESET_MIN = 24'h200000;
  localparam logic [RMS_W-1:0]  RMS_MAX       = 24'hFFFFFF;
  localparam logic [FAIL_W-1:0] FAIL_MAX      = 7'd127;

  typedef enum logic [CIDX_W-1:0] {
    CFG_DC_START  = 3'd0,
    CFG_DC_COUNT  = 3'd1,
    CFG_RMS_COUNT = 3'd2,
    CFG_LOW_LIM   = 3'd3,
    CFG_HIGH_LIM  = 3'd4
  } cfg_index_t;

  typedef enum logic [3:0] {
    L_IDLE, L_MEAN, L_WALK, L_SQ1, L_SQ2, L_SQ3, L_SQ4, L_DIV, L_SQRT, L_DONE
  } lane_state_t;

  typedef enum logic [2:0] {
    S_TAKE, S_START, S_READ, S_FEED, S_FINISH, S_WAIT, S_EMIT
  } top_state_t;

  typedef struct packed {
    logic start;
    logic feed;
    logic finish;
  } lane_ctl_t;

  typedef struct packed {
    logic ready;
    logic done;
  } lane_stat_t;

  typedef struct packed {
    logic clr_group;
    logic clr_run;
    logic load;
  } merge_ctl_t;

endpackage

// File: sv/erlc_ifs.sv
// Channel interfaces for the element RMS level check block.
// Depends on erlc_pkg.
interface erlc_sample_if;
  logic                         valid;
  logic                         ready;
  logic [erlc_pkg::WORD_W-1:0]  sample_word;
  logic [erlc_pkg::POS_W-1:0]   sample_position;
  logic                         end_of_pair;
  logic                         group_start;
  logic                         run_start;
  modport source (output valid, sample_word, sample_position, end_of_pair, group_start,
                  run_start, input ready);
  modport sink (input valid, sample_word, sample_position, end_of_pair, group_start,
                run_start, output ready);
endinterface

interface erlc_result_if;
  logic                         valid;
  logic                         ready;
  logic [erlc_pkg::ELEM_W-1:0]  element;
  logic [erlc_pkg::RMS_W-1:0]   rms_value;
  logic                         failed;
  logic [erlc_pkg::FAIL_W-1:0]  failure_count;
  logic [erlc_pkg::RMS_W-1:0]   rms_minimum;
  logic [erlc_pkg::RMS_W-1:0]   rms_maximum;
  logic                         last;
  modport source (output valid, element, rms_value, failed, failure_count, rms_minimum,
                  rms_maximum, last, input ready);
  modport sink (input valid, element, rms_value, failed, failure_count, rms_minimum,
                rms_maximum, last, output ready);
endinterface

interface erlc_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [erlc_pkg::CIDX_W-1:0]  index;
  logic [erlc_pkg::RMS_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: sv/erlc_lane.sv
// One channel lane: DC mean divider, squared-deviation walk, variance divider
// and integer square root, sharing one shift register. Depends on erlc_pkg.
module erlc_lane (
  input  logic                                clk,
  input  logic                                rst,
  input  erlc_pkg::lane_ctl_t                 ctl,
  input  logic signed [erlc_pkg::SUM_W-1:0]   dc_sum,
  input  logic [erlc_pkg::DCW_W-1:0]          dc_count,
  input  logic [erlc_pkg::CNT_W-1:0]          n,
  input  logic signed [erlc_pkg::SAMPLE_W-1:0] sample,
  output erlc_pkg::lane_stat_t                stat,
  output logic [erlc_pkg::RMS_W-1:0]          rms
);
  import erlc_pkg::*;

  lane_state_t state, state_next;
  logic [ITER_W-1:0]        iter;
  logic                     neg;
  logic                     cnt_zero;
  logic [CNT_W-1:0]         n_q;
  logic [DCW_W-1:0]         divisor;
  logic [DCW_W-1:0]         rem;
  logic [ACC_W-1:0]         dq;
  logic signed [MEAN_W-1:0] mean;
  logic [MEAN_W-1:0]        a;
  logic [MEAN_W-1:0]        prod;
  logic [ACC_W-1:0]         acc;
  logic [ROOT_W-1:0]        root;
  logic [MEAN_W-1:0]        srem;

  logic [SUM_W-1:0]         sum_mag;
  logic [DCW_W:0]           trial;
  logic                     ge;
  logic signed [MEAN_W:0]   dev;
  logic [MEAN_W-1:0]        srem_sh;
  logic [MEAN_W-1:0]        strial;
  logic [32:0]              q33;

  always_comb begin
    sum_mag = dc_sum[SUM_W-1] ? SUM_W'(-dc_sum) : dc_sum;
    trial   = {rem, dq[ACC_W-1]} - {1'b0, divisor};
    ge      = !trial[DCW_W];
    dev     = ((MEAN_W+1)'(sample) <<< 8) - (MEAN_W+1)'(mean);
    srem_sh = {srem[MEAN_W-3:0], dq[ACC_W-1:ACC_W-2]};
    strial  = {root, 2'b01};
    // quotient as it stands once the current bit is shifted in
    q33     = {dq[31:0], ge};
  end

  always_comb begin
    state_next = state;
    unique case (state)
      L_IDLE, L_DONE: if (ctl.start) state_next = L_MEAN;
      L_MEAN: if (iter == ITER_W'(ACC_W-1)) state_next = L_WALK;
      L_WALK: begin
        if (ctl.finish) state_next = L_DIV;
        else if (ctl.feed) state_next = L_SQ1;
      end
      L_SQ1: state_next = L_SQ2;
      L_SQ2: state_next = L_SQ3;
      L_SQ3: state_next = L_SQ4;
      L_SQ4: state_next = L_WALK;
      L_DIV: if (iter == ITER_W'(ACC_W-1)) state_next = L_SQRT;
      L_SQRT: if (iter == ITER_W'(ROOT_W-1)) state_next = L_DONE;
      default: state_next = L_IDLE;
    endcase
  end

  always_comb begin
    stat.ready = (state == L_WALK);
    stat.done  = (state == L_DONE);
    if (n_q == '0) rms = '0;
    else if (root > ROOT_W'(RMS_MAX)) rms = RMS_MAX;
    else rms = root[RMS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      iter  <= '0;
    end else begin
      state <= state_next;
      if (state_next != state) iter <= '0;
      else iter <= iter + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      L_IDLE, L_DONE: begin
        if (ctl.start) begin
          neg      <= dc_sum[SUM_W-1];
          cnt_zero <= (dc_count == '0);
          n_q      <= n;
          divisor  <= dc_count;
          rem      <= '0;
          dq       <= ACC_W'({sum_mag, 8'b0} + 33'(dc_count >> 1));
        end
      end
      L_MEAN: begin
        rem <= ge ? trial[DCW_W-1:0] : {rem[DCW_W-2:0], dq[ACC_W-1]};
        dq  <= {dq[ACC_W-2:0], ge};
        if (iter == ITER_W'(ACC_W-1)) begin
          acc <= '0;
          // mean is ready before the first sample is fed
          if (cnt_zero) mean <= '0;
          else mean <= neg ? -MEAN_W'(q33) : MEAN_W'(q33);
        end
      end
      L_WALK: begin
        if (ctl.feed) a <= dev[MEAN_W] ? MEAN_W'(-dev) : MEAN_W'(dev);
        if (ctl.finish) begin
          dq      <= acc;
          rem     <= '0;
          divisor <= DCW_W'(n_q);
        end
      end
      L_SQ1: prod <= MEAN_W'(a[16:0] * a[16:0]);
      L_SQ2: begin
        acc  <= acc + ACC_W'(prod);
        prod <= MEAN_W'(a[33:17] * a[16:0]);
      end
      L_SQ3: begin
        acc  <= acc + (ACC_W'(prod) << 18);
        prod <= MEAN_W'(a[33:17] * a[33:17]);
      end
      L_SQ4: acc <= acc + (ACC_W'(prod) << 34);
      L_DIV: begin
        rem <= ge ? trial[DCW_W-1:0] : {rem[DCW_W-2:0], dq[ACC_W-1]};
        dq  <= {dq[ACC_W-2:0], ge};
        root <= '0;
        srem <= '0;
      end
      L_SQRT: begin
        if (srem_sh >= strial) begin
          srem <= srem_sh - strial;
          root <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          srem <= srem_sh;
          root <= {root[ROOT_W-2:0], 1'b0};
        end
        dq <= {dq[ACC_W-3:0], 2'b00};
      end
      default: ;
    endcase
  end

endmodule

// File: sv/erlc_merge.sv
// Merging stage: limit check, failure count, running min/max and the
// registered result port, two beats per pair. Depends on erlc_pkg, erlc_ifs.
module erlc_merge #(
  parameter int CHANNEL_PAIRS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  erlc_pkg::merge_ctl_t          ctl,
  input  logic [erlc_pkg::RMS_W-1:0]    rms_even,
  input  logic [erlc_pkg::RMS_W-1:0]    rms_odd,
  input  logic [erlc_pkg::RMS_W-1:0]    low_limit,
  input  logic [erlc_pkg::RMS_W-1:0]    high_limit,
  erlc_result_if.source                 result,
  output logic                          busy
);
  import erlc_pkg::*;

  localparam int PW = (CHANNEL_PAIRS > 1) ? $clog2(CHANNEL_PAIRS) : 1;

  logic [PW-1:0]     pair;
  logic [FAIL_W-1:0] fail_cnt;
  logic [RMS_W-1:0]  rmin, rmax, odd_hold, out_rms;
  logic [ELEM_W-1:0] out_elem;
  logic              valid, out_fail, out_last;

  logic [RMS_W-1:0]  cur;
  logic              fail;
  logic              step;

  always_comb begin
    cur  = ctl.load ? rms_even : odd_hold;
    fail = (cur > high_limit) || (cur < low_limit);
    step = ctl.load || (valid && result.ready && !out_last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= 1'b0;
      out_last <= 1'b0;
      pair     <= '0;
      fail_cnt <= '0;
      rmin     <= RMS_RESET_MIN;
      rmax     <= '0;
    end else begin
      if (ctl.clr_group) begin
        fail_cnt <= '0;
        pair     <= '0;
      end
      if (ctl.clr_run) begin
        rmin <= RMS_RESET_MIN;
        rmax <= '0;
      end
      if (step) begin
        if (fail && fail_cnt < FAIL_MAX) fail_cnt <= fail_cnt + 1'b1;
        if (cur < rmin) rmin <= cur;
        if (cur > rmax) rmax <= cur;
        out_rms  <= cur;
        out_fail <= fail;
        out_elem <= ELEM_W'({pair, !ctl.load});
        out_last <= !ctl.load;
        valid    <= 1'b1;
        if (ctl.load) odd_hold <= rms_odd;
      end else if (valid && result.ready) begin
        // odd beat taken: close the pair
        valid    <= 1'b0;
        out_last <= 1'b0;
        pair     <= (int'(pair) + 1 >= CHANNEL_PAIRS) ? '0 : pair + 1'b1;
      end
    end
  end

  assign result.valid         = valid;
  assign result.element       = out_elem;
  assign result.rms_value     = out_rms;
  assign result.failed        = out_fail;
  assign result.failure_count = fail_cnt;
  assign result.rms_minimum   = rmin;
  assign result.rms_maximum   = rmax;
  assign result.last          = out_last;
  assign busy                 = valid;

endmodule

// File: sv/element_rms_level_check.sv
// Channel   | Dir | Beat
// sample    | in  | one packed word of a channel pair, with position and flags
// result    | out | one element result; two beats per pair, odd one has last
// cfg       | in  | register write, index and data; always ready
// Words without end_of_pair are taken back to back. After a word with
// end_of_pair the next word is taken only once both result beats of the
// pair have gone out; on the way the pair passes the two 64-step shift
// dividers, the 32-step square root and, per buffered sample (RMS sample
// count, capped at buffer depth), one walk state plus squaring states SQ1
// to SQ4, both lanes side by side. Reset is synchronous; no clearing pass.
// Sample input stays low while a pair is computed or its results wait.
// Top level of the element RMS level check; depends on erlc_pkg, erlc_ifs,
// erlc_lane, erlc_merge and element_rms_level_check_assert.svh.
`include "element_rms_level_check_assert.svh"
module element_rms_level_check #(
  parameter int RMS_BUFFER_DEPTH   = 64,
  parameter int CHANNEL_PAIRS      = 32,
  parameter int POSITIONS_PER_PAIR = 1024
) (
  input logic           clk,
  input logic           rst,
  erlc_sample_if.sink   sample,
  erlc_result_if.source result,
  erlc_cfg_if.sink      cfg
);
  import erlc_pkg::*;

  localparam int AW = $clog2(RMS_BUFFER_DEPTH);

  top_state_t state, state_next;

  logic [POS_W-1:0]  win_first;
  logic [DCW_W-1:0]  dc_count;
  logic [CNT_W-1:0]  rms_count;
  logic [RMS_W-1:0]  low_limit, high_limit;

  logic signed [SUM_W-1:0] sum_even, sum_odd;
  logic [WORD_W-1:0] mem [RMS_BUFFER_DEPTH];
  logic [WORD_W-1:0] rd_data;
  logic [CNT_W-1:0]  j;
  logic [CNT_W-1:0]  n;

  lane_ctl_t  lctl;
  lane_stat_t stat_even, stat_odd;
  merge_ctl_t mctl;
  logic [RMS_W-1:0] rms_even, rms_odd;
  logic merge_busy;

  logic accept, in_window, lanes_ready;
  logic [POS_W:0] win_end;

  assign cfg.ready    = 1'b1;
  assign sample.ready = (state == S_TAKE);
  assign accept       = sample.valid && sample.ready;
  assign lanes_ready  = stat_even.ready && stat_odd.ready;
  assign n = (int'(rms_count) > RMS_BUFFER_DEPTH) ? CNT_W'(RMS_BUFFER_DEPTH) : rms_count;
  assign win_end   = {1'b0, win_first} + (POS_W+1)'(dc_count);
  assign in_window = (sample.sample_position >= win_first) &&
                     ({1'b0, sample.sample_position} < win_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      win_first  <= 10'd512;
      dc_count   <= 9'd128;
      rms_count  <= 7'd64;
      low_limit  <= '0;
      high_limit <= RMS_MAX;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        CFG_DC_START:  win_first  <= cfg.data[POS_W-1:0];
        CFG_DC_COUNT:  dc_count   <= cfg.data[DCW_W-1:0];
        CFG_RMS_COUNT: rms_count  <= cfg.data[CNT_W-1:0];
        CFG_LOW_LIM:   low_limit  <= cfg.data;
        CFG_HIGH_LIM:  high_limit <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_TAKE:   if (accept && sample.end_of_pair) state_next = S_START;
      S_START:  state_next = (n == '0) ? S_FINISH : S_READ;
      S_READ:   state_next = S_FEED;
      S_FEED: begin
        if (lanes_ready) state_next = (j == n - 1'b1) ? S_FINISH : S_READ;
      end
      S_FINISH: if (lanes_ready) state_next = S_WAIT;
      S_WAIT:   if (stat_even.done && stat_odd.done) state_next = S_EMIT;
      S_EMIT:   if (!merge_busy) state_next = S_TAKE;
      default:  state_next = S_TAKE;
    endcase
  end

  always_comb begin
    lctl.start     = (state == S_START);
    lctl.feed      = (state == S_FEED) && lanes_ready;
    lctl.finish    = (state == S_FINISH) && lanes_ready;
    mctl.clr_group = accept && sample.group_start;
    mctl.clr_run   = accept && sample.run_start;
    mctl.load      = (state == S_WAIT) && stat_even.done && stat_odd.done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_TAKE;
      sum_even <= '0;
      sum_odd  <= '0;
      j        <= '0;
    end else begin
      state <= state_next;
      if (accept && int'(sample.sample_position) < POSITIONS_PER_PAIR && in_window) begin
        sum_even <= sum_even + SUM_W'($signed(sample.sample_word[15:0]));
        sum_odd  <= sum_odd + SUM_W'($signed(sample.sample_word[31:16]));
      end
      if (state == S_START) begin
        // lanes latch the sums on this edge
        sum_even <= '0;
        sum_odd  <= '0;
        j        <= '0;
      end
      if (lctl.feed) j <= j + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && int'(sample.sample_position) < POSITIONS_PER_PAIR &&
        sample.sample_position < POS_W'(rms_count) &&
        int'(sample.sample_position) < RMS_BUFFER_DEPTH) begin
      mem[AW'(sample.sample_position)] <= sample.sample_word;
    end
    if (state == S_READ) rd_data <= mem[AW'(j)];
  end

  erlc_lane u_lane_even (
    .clk      (clk),
    .rst      (rst),
    .ctl      (lctl),
    .dc_sum   (sum_even),
    .dc_count (dc_count),
    .n        (n),
    .sample   ($signed(rd_data[15:0])),
    .stat     (stat_even),
    .rms      (rms_even)
  );

  erlc_lane u_lane_odd (
    .clk      (clk),
    .rst      (rst),
    .ctl      (lctl),
    .dc_sum   (sum_odd),
    .dc_count (dc_count),
    .n        (n),
    .sample   ($signed(rd_data[31:16])),
    .stat     (stat_odd),
    .rms      (rms_odd)
  );

  erlc_merge #(
    .CHANNEL_PAIRS (CHANNEL_PAIRS)
  ) u_merge (
    .clk        (clk),
    .rst        (rst),
    .ctl        (mctl),
    .rms_even   (rms_even),
    .rms_odd    (rms_odd),
    .low_limit  (low_limit),
    .high_limit (high_limit),
    .result     (result),
    .busy       (merge_busy)
  );

  `ERLC_ASSERT_ALWAYS(a_no_overlap, !(sample.ready && result.valid), "input open while results wait")
  `ERLC_ASSERT_NEXT(a_odd_follows, result.valid && result.ready && !result.last, result.valid && result.last, "odd beat missing after even")
  `ERLC_ASSERT_ALWAYS(a_min_le_max, !result.valid || (result.rms_minimum <= result.rms_maximum), "running min above max")

endmodule

// File: dv/erlc_level_checker.sv
// Checker for the element RMS level check: predicts each element result
// from the accepted sample and register beats and compares the result beats.
// Depends on erlc_pkg and erlc_ifs.
module erlc_level_checker (
  input  logic   clk,
  input  logic   rst,
  erlc_sample_if smp,
  erlc_result_if res,
  erlc_cfg_if    cfg,
  output int     mismatches,
  output int     pending,
  output int     pairs_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import erlc_pkg::*;

  typedef struct {
    logic [ELEM_W-1:0] element;
    logic [RMS_W-1:0]  rms_value;
    logic              failed;
    logic [FAIL_W-1:0] failure_count;
    logic [RMS_W-1:0]  rms_minimum;
    logic [RMS_W-1:0]  rms_maximum;
    logic              last;
  } element_result_t;

  element_result_t element_results_due[$];

  logic [WORD_W-1:0] wave_mem [64];
  longint            sum_even, sum_odd;
  logic [4:0]        pair_idx;
  logic [FAIL_W-1:0] fail_cnt;
  logic [RMS_W-1:0]  min_rms, max_rms;
  logic [9:0]        win_start;
  logic [8:0]        win_count;
  logic [6:0]        rms_count;
  logic [RMS_W-1:0]  lim_low, lim_high;

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r, t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic logic [RMS_W-1:0] lane_rms(bit odd, longint sum);
    longint      mean_q8, mag, d;
    logic [63:0] acc, root;
    int          n;
    n = (rms_count < 64) ? rms_count : 64;
    if (n == 0) return '0;
    mean_q8 = 0;
    if (win_count != 0) begin
      mag = (sum < 0) ? -sum : sum;
      mag = (mag * 256 + win_count / 2) / win_count;
      mean_q8 = (sum < 0) ? -mag : mag;
    end
    acc = 0;
    for (int j = 0; j < n; j++) begin
      d = (odd ? longint'($signed(wave_mem[j][31:16])) : longint'($signed(wave_mem[j][15:0])))
          * 256 - mean_q8;
      acc += d * d;
    end
    root = int_sqrt(acc / n);
    return (root > RMS_MAX) ? RMS_MAX : root[RMS_W-1:0];
  endfunction

  function automatic void predict_element(bit odd, longint sum);
    element_result_t e;
    e.rms_value = lane_rms(odd, sum);
    e.failed = (e.rms_value > lim_high) || (e.rms_value < lim_low);
    if (e.failed && fail_cnt < FAIL_MAX) fail_cnt++;
    if (e.rms_value < min_rms) min_rms = e.rms_value;
    if (e.rms_value > max_rms) max_rms = e.rms_value;
    e.element = {pair_idx, odd};
    e.failure_count = fail_cnt;
    e.rms_minimum = min_rms;
    e.rms_maximum = max_rms;
    e.last = odd;
    element_results_due.push_back(e);
  endfunction

  always @(posedge clk) begin
    element_result_t e;
    if (rst) begin
      element_results_due.delete();
      sum_even = 0;
      sum_odd = 0;
      pair_idx = '0;
      fail_cnt = '0;
      min_rms = RMS_RESET_MIN;
      max_rms = '0;
      win_start = 10'd512;
      win_count = 9'd128;
      rms_count = 7'd64;
      lim_low = '0;
      lim_high = RMS_MAX;
      mismatches = 0;
      pairs_seen = 0;
      pending = 0;
    end else begin
      if (res.valid && res.ready) begin
        if (element_results_due.size() == 0) begin
          $error("result beat with nothing expected: element %0d", res.element);
          mismatches++;
        end else begin
          e = element_results_due.pop_front();
          if (res.element !== e.element) begin
            $error("element: expected %0d, got %0d", e.element, res.element);
            mismatches++;
          end
          if (res.rms_value !== e.rms_value) begin
            $error("rms_value: expected %h, got %h", e.rms_value, res.rms_value);
            mismatches++;
          end
          if (res.failed !== e.failed) begin
            $error("failed: expected %b, got %b", e.failed, res.failed);
            mismatches++;
          end
          if (res.failure_count !== e.failure_count) begin
            $error("failure_count: expected %0d, got %0d", e.failure_count, res.failure_count);
            mismatches++;
          end
          if (res.rms_minimum !== e.rms_minimum) begin
            $error("rms_minimum: expected %h, got %h", e.rms_minimum, res.rms_minimum);
            mismatches++;
          end
          if (res.rms_maximum !== e.rms_maximum) begin
            $error("rms_maximum: expected %h, got %h", e.rms_maximum, res.rms_maximum);
            mismatches++;
          end
          if (res.last !== e.last) begin
            $error("last: expected %b, got %b", e.last, res.last);
            mismatches++;
          end
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg_index_t'(cfg.index))
          CFG_DC_START:  win_start = cfg.data[9:0];
          CFG_DC_COUNT:  win_count = cfg.data[8:0];
          CFG_RMS_COUNT: rms_count = cfg.data[6:0];
          CFG_LOW_LIM:   lim_low = cfg.data;
          CFG_HIGH_LIM:  lim_high = cfg.data;
          default: ;
        endcase
      end
      if (smp.valid && smp.ready) begin
        if (smp.group_start) begin
          fail_cnt = '0;
          pair_idx = '0;
        end
        if (smp.run_start) begin
          min_rms = RMS_RESET_MIN;
          max_rms = '0;
        end
        // take the word before any end-of-pair computation
        if (smp.sample_position >= win_start &&
            int'(smp.sample_position) < int'(win_start) + int'(win_count)) begin
          sum_even += longint'($signed(smp.sample_word[15:0]));
          sum_odd  += longint'($signed(smp.sample_word[31:16]));
        end
        if (smp.sample_position < rms_count && smp.sample_position < 64)
          wave_mem[smp.sample_position[5:0]] = smp.sample_word;
        if (smp.end_of_pair) begin
          predict_element(1'b0, sum_even);
          predict_element(1'b1, sum_odd);
          sum_even = 0;
          sum_odd = 0;
          pair_idx = pair_idx + 5'd1;
          pairs_seen++;
        end
      end
      pending = element_results_due.size();
    end
  end
endmodule

// File: dv/element_rms_level_check_tb.sv
// Testbench top for the element RMS level check: drives sample, register
// and result-ready traffic and gives the verdict. Depends on erlc_pkg,
// erlc_ifs, erlc_level_checker and the block itself.
module element_rms_level_check_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import erlc_pkg::*;

  logic clk;
  logic rst;
  int   mismatches, pending, pairs_seen;
  int   words_sent;
  int   idle_pct, stall_pct;
  int   rms_n;
  bit   written [64];

  erlc_sample_if smp ();
  erlc_result_if res ();
  erlc_cfg_if    cfg ();

  element_rms_level_check i_dut (
    .clk(clk), .rst(rst), .sample(smp), .result(res), .cfg(cfg)
  );

  erlc_level_checker i_checker (
    .clk(clk), .rst(rst), .smp(smp), .res(res), .cfg(cfg),
    .mismatches(mismatches), .pending(pending), .pairs_seen(pairs_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Simulation FAILED");
    $finish;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (rst) res.ready <= 1'b0;
    else res.ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_word(logic [31:0] word, logic [9:0] pos, bit eop, bit gs, bit rs);
    if ($urandom_range(99) < idle_pct) begin
      smp.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    smp.valid <= 1'b1;
    smp.sample_word <= word;
    smp.sample_position <= pos;
    smp.end_of_pair <= eop;
    smp.group_start <= gs;
    smp.run_start <= rs;
    @(posedge clk);
    while (!smp.ready) @(posedge clk);
    if (pos < rms_n) written[pos[5:0]] = 1'b1;
    words_sent++;
  endtask

  // close a pair: cover any buffered position not yet written, then end it
  task automatic end_pair(logic [31:0] word, bit gs, bit rs);
    for (int p = 0; p < rms_n; p++)
      if (!written[p]) send_word($urandom, p[9:0], 1'b0, 1'b0, 1'b0);
    send_word(word, 10'($urandom_range(63)), 1'b1, gs, rs);
  endtask

  task automatic write_reg(cfg_index_t idx, int value);
    // drop the last sample beat and let the checker see it first
    smp.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (4) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= RMS_W'(value);
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    if (idx == CFG_RMS_COUNT) rms_n = ((value & 127) < 64) ? (value & 127) : 64;
  endtask

  function automatic logic [31:0] rand_word();
    logic [15:0] lo, hi;
    lo = 16'($urandom);
    hi = 16'($urandom);
    case ($urandom_range(7))
      0: lo = 16'h8000;
      1: hi = 16'h7FFF;
      2: begin lo = 16'h7FFF; hi = 16'h8000; end
      3: begin lo = 16'($urandom_range(3)); hi = 16'hFFFF - 16'($urandom_range(3)); end
      default: ;
    endcase
    return {hi, lo};
  endfunction

  task automatic random_pair();
    int len;
    logic [9:0] pos;
    len = $urandom_range(24, 1);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(9))
        0, 1, 2, 3: pos = 10'($urandom_range(63));
        4, 5, 6:    pos = 10'(i_checker.win_start + $urandom_range(15));
        default:    pos = 10'($urandom);
      endcase
      send_word(rand_word(), pos, 1'b0, (i == 0) && ($urandom_range(9) == 0),
                (i == 0) && ($urandom_range(19) == 0));
    end
    end_pair(rand_word(), $urandom_range(29) == 0, $urandom_range(39) == 0);
  endtask

  task automatic random_config();
    case ($urandom_range(3))
      0: write_reg(CFG_DC_START, 0);
      1: write_reg(CFG_DC_START, 1023);
      default: write_reg(CFG_DC_START, $urandom_range(1023));
    endcase
    case ($urandom_range(5))
      0: write_reg(CFG_DC_COUNT, 0);
      1: write_reg(CFG_DC_COUNT, 1);
      2: write_reg(CFG_DC_COUNT, 511);
      default: write_reg(CFG_DC_COUNT, $urandom_range(256, 1));
    endcase
    case ($urandom_range(6))
      0: write_reg(CFG_RMS_COUNT, 1);
      1: write_reg(CFG_RMS_COUNT, 127);
      2: write_reg(CFG_RMS_COUNT, 64);
      default: write_reg(CFG_RMS_COUNT, $urandom_range(16, 1));
    endcase
    write_reg(CFG_LOW_LIM, ($urandom_range(4) == 0) ? 24'd0 : 24'($urandom_range(24'h600000)));
    write_reg(CFG_HIGH_LIM, ($urandom_range(4) == 0) ? RMS_MAX
                                                     : 24'($urandom_range(24'hFFFFFF, 24'h300000)));
  endtask

  initial begin
    rst = 1'b1;
    smp.valid = 1'b0;
    smp.sample_word = '0;
    smp.sample_position = '0;
    smp.end_of_pair = 1'b0;
    smp.group_start = 1'b0;
    smp.run_start = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = CFG_DC_START;
    cfg.data = '0;
    idle_pct = 0;
    stall_pct = 0;
    rms_n = 64;
    words_sent = 0;
    foreach (written[p]) written[p] = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: full-scale lanes, window edges, flags, zero DC count,
    // empty RMS set, all-failing limits, capped RMS count
    write_reg(CFG_RMS_COUNT, 2);
    write_reg(CFG_DC_START, 0);
    write_reg(CFG_DC_COUNT, 3);
    send_word(32'h7FFF_8000, 10'd0, 1'b0, 1'b1, 1'b1);
    send_word(32'h8000_7FFF, 10'd1, 1'b0, 1'b0, 1'b0);
    send_word(32'h0000_0000, 10'd2, 1'b0, 1'b0, 1'b0);
    send_word(32'hFFFF_FFFF, 10'd1023, 1'b0, 1'b0, 1'b0);
    end_pair(32'h8000_8000, 1'b0, 1'b0);
    write_reg(CFG_DC_COUNT, 0);
    send_word(32'h7FFF_7FFF, 10'd0, 1'b0, 1'b0, 1'b0);
    end_pair(32'h0001_FFFF, 1'b0, 1'b0);
    write_reg(CFG_LOW_LIM, RMS_MAX);
    write_reg(CFG_HIGH_LIM, 0);
    write_reg(CFG_DC_START, 1023);
    write_reg(CFG_DC_COUNT, 511);
    send_word(32'h1234_8765, 10'd1023, 1'b0, 1'b0, 1'b0);
    end_pair(32'h7FFF_8000, 1'b0, 1'b0);
    write_reg(CFG_RMS_COUNT, 0);
    end_pair(32'hFFFF_0000, 1'b1, 1'b0);
    write_reg(CFG_RMS_COUNT, 127);
    end_pair(32'h8000_7FFF, 1'b0, 1'b1);

    for (int round = 0; round < 8; round++) begin
      case (round % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 74; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 74; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      random_config();
      while (words_sent < 200 + (round + 1) * 220) begin
        if ($urandom_range(9) == 0)
          send_word($urandom, 10'($urandom), 1'b0, 1'($urandom_range(1)),
                    1'($urandom_range(1)));
        else
          random_pair();
        if (round == 3 && words_sent > 200 + round * 220 + 100 && pending != 0) begin
          // hold the sender until every due result is out
          smp.valid <= 1'b0;
          @(posedge clk);
          wait (pending == 0);
          @(posedge clk);
        end
      end
    end
    smp.valid <= 1'b0;
    @(posedge clk);

    wait (pending == 0);
    repeat (600) @(posedge clk);
    $display("Sent %0d sample words making %0d channel pairs over four idle patterns,",
             words_sent, pairs_seen);
    $display("with register settings changed between rounds, extremes included.");
    if (mismatches == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
